// ----- hw/rtl/sop_pkg.sv -----
// Shared types and constants of the sandbox offset prefetcher.
package sop_pkg;

  localparam int unsigned NumSlots  = 16;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned OffW      = 6;
  localparam int unsigned WaitDepth = 32;
  localparam int unsigned WaitW     = 5;
  localparam int unsigned NumTgt    = 5;
  localparam int unsigned TgtDemand = 0;
  localparam int unsigned TgtInsert = 4;
  localparam int unsigned MaxOut    = 64;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 9;
  localparam int unsigned ThrW      = 11;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDegree     = 3'd0,
    CfgStreamEn   = 3'd1,
    CfgStreamLen  = 3'd2,
    CfgPhaseLen   = 3'd3,
    CfgOffCycled  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StScan,
    StUpdate,
    StSort,
    StPush,
    StPop,
    StEmM,
    StEmS,
    StEmLa,
    StFlush
  } state_e;

  typedef struct packed {
    logic start;
    logic insert;
    logic clear;
  } sb_ctrl_t;

  typedef struct packed {
    logic              done;
    logic [NumTgt-1:0] hit;
  } sb_stat_t;

endpackage

// ----- hw/rtl/sop_sandbox.sv -----
// Sandbox address set: memory, fill count and a one-entry-per-cycle search.
module sop_sandbox #(
  parameter int unsigned AddrW = 58,
  parameter int unsigned Depth = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sop_pkg::sb_ctrl_t    ctrl_i,
  input  logic [AddrW-1:0]     tgt_i [sop_pkg::NumTgt],
  output sop_pkg::sb_stat_t    stat_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [AddrW-1:0] mem [Depth];
  logic [AddrW-1:0] rdata_q;
  logic [CntW-1:0]  fill_q, fill_d, idx_q, idx_d;
  logic             scan_q, scan_d, rv_q, rv_d;
  logic [sop_pkg::NumTgt-1:0] hit_q, hit_d;
  logic             rd_en, ins_ok, done;

  assign rd_en  = scan_q && (idx_q < fill_q);
  assign done   = scan_q && !rd_en && !rv_q;
  assign ins_ok = !hit_q[sop_pkg::TgtInsert] && (fill_q < CntW'(Depth));

  always_comb begin
    scan_d = scan_q;
    idx_d  = idx_q;
    rv_d   = rd_en;
    hit_d  = hit_q;
    fill_d = fill_q;
    if (rv_q) begin
      for (int t = 0; t < sop_pkg::NumTgt; t++) begin
        if (rdata_q == tgt_i[t]) hit_d[t] = 1'b1;
      end
    end
    if (rd_en) idx_d = idx_q + CntW'(1);
    if (done) scan_d = 1'b0;
    if (ctrl_i.start) begin
      scan_d = 1'b1;
      idx_d  = '0;
      rv_d   = 1'b0;
      hit_d  = '0;
    end
    if (ctrl_i.clear) begin
      fill_d = '0;
    end else if (ctrl_i.insert && ins_ok) begin
      fill_d = fill_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      idx_q  <= '0;
      scan_q <= 1'b0;
      rv_q   <= 1'b0;
      hit_q  <= '0;
    end else begin
      fill_q <= fill_d;
      idx_q  <= idx_d;
      scan_q <= scan_d;
      rv_q   <= rv_d;
      hit_q  <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert && ins_ok && !ctrl_i.clear) begin
      mem[fill_q[IdxW-1:0]] <= tgt_i[sop_pkg::TgtInsert];
    end
    if (rd_en) rdata_q <= mem[idx_q[IdxW-1:0]];
  end

  assign stat_o.done = done;
  assign stat_o.hit  = hit_q;

endmodule

// ----- hw/rtl/sandbox_offset_prefetcher_top.sv -----
// Sandbox offset prefetcher: scoring sequencer, round-end reordering and prefetch emission.
// After acceptance busy stays high through the sandbox search and score update, the sort and
// wait-queue exchange at a round end, then the emission of both signs with lookaheads per
// matching slot (fewer after a degree cutoff) and a flush state; nothing stalls it.
// Results are one-cycle strobes; the last is on the ports in the first cycle with busy low.
// Reset is asynchronous and restores all scoring state and the default configuration.
module sandbox_offset_prefetcher_top #(
  parameter int unsigned BLOCK_ADDR_BITS      = 58,
  parameter int unsigned BLOCKS_PER_PAGE_LOG2 = 6,
  parameter int unsigned SANDBOX_DEPTH        = 256,
  parameter int unsigned SCORE_BITS           = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [BLOCK_ADDR_BITS-1:0]      block_address_i,
  input  logic                            cfg_we_i,
  input  logic [sop_pkg::CfgIdxW-1:0]     cfg_addr_i,
  input  logic [sop_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output logic                            out_valid_o,
  output logic [BLOCK_ADDR_BITS-1:0]      prefetch_address_o,
  output logic [5:0]                      priority_index_o,
  output logic                            last_of_run_o
);

  localparam int unsigned AB  = BLOCK_ADDR_BITS;
  localparam int unsigned BL  = BLOCKS_PER_PAGE_LOG2;
  localparam int unsigned SB  = SCORE_BITS;
  localparam int unsigned PoW = ((BL > 7) ? BL : 7) + 3;
  localparam int unsigned NS  = sop_pkg::NumSlots;

  sop_pkg::state_e state_q, state_d;

  logic [4:0] deg_q, deg_d, oc_q, oc_d;
  logic       sde_q, sde_d;
  logic [1:0] sdl_q, sdl_d;
  logic [8:0] pl_q, pl_d, pd_q, pd_d;

  logic [sop_pkg::OffW-1:0] soff_q [NS];
  logic [sop_pkg::OffW-1:0] soff_d [NS];
  logic [SB-1:0]            sc_q [NS];
  logic [SB-1:0]            sc_d [NS];
  logic [sop_pkg::OffW-1:0] wq_q [sop_pkg::WaitDepth];
  logic [sop_pkg::OffW-1:0] wq_d [sop_pkg::WaitDepth];
  logic [sop_pkg::WaitW-1:0] whead_q, whead_d;
  logic [5:0] wcnt_q, wcnt_d;
  logic [3:0] cs_q, cs_d;

  logic [AB-1:0] addr_q, addr_d;
  logic [AB-1:0] tgt_q [sop_pkg::NumTgt];
  logic [AB-1:0] tgt_d [sop_pkg::NumTgt];
  logic [sop_pkg::NumTgt-1:0] tv_q, tv_d;
  logic [4:0] k_q, k_d;

  logic        sg_q, sg_d;
  logic [5:0]  m_q, m_d;
  logic [NS-1:0] pend_q, pend_d;
  logic [3:0]  esel_q, esel_d;
  logic [2:0]  la_q, la_d;
  logic [sop_pkg::ThrW-1:0] thr_q, thr_d;
  logic signed [PoW-1:0] po_q, po_d;
  logic [6:0]  cnt_q, cnt_d, n_q, n_d;
  logic        hbv_q, hbv_d;
  logic [AB-1:0] hba_q, hba_d;
  logic [5:0]  hbp_q, hbp_d;
  logic        ov_q, ov_d, ol_q, ol_d;
  logic [AB-1:0] oa_q, oa_d;
  logic [5:0]  op_q, op_d;

  sop_pkg::sb_ctrl_t sb_ctrl;
  sop_pkg::sb_stat_t sb_stat;

  logic        accept, phase_end, sel_found, la_ok, sign_stop;
  logic [4:0]  ncyc;
  logic [2:0]  lmax;
  logic [3:0]  sel;
  logic signed [PoW-1:0] in_off, in_d, so1, so2, so3, po0, e_d;
  logic [2:0]  inc;
  logic [SB:0] sc_sum;
  logic [6:0]  tgt_m, soff_ext;

  function automatic logic in_page(logic signed [PoW-1:0] v);
    return v[PoW-1:BL] == '0;
  endfunction

  assign accept    = start && (state_q == sop_pkg::StIdle);
  assign busy      = (state_q != sop_pkg::StIdle);
  assign phase_end = (pl_q != 9'd0) && (pd_q == pl_q);
  assign ncyc      = (oc_q > 5'd16) ? 5'd16 : oc_q;
  assign lmax      = sde_q ? ({1'b0, sdl_q} + 3'd1) : 3'd1;
  assign la_ok     = (la_q <= lmax);
  assign sign_stop = (cnt_q > {2'b00, deg_q});

  always_comb begin
    sel       = '0;
    sel_found = 1'b0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel       = 4'(i);
        sel_found = 1'b1;
      end
    end
  end

  assign in_off = PoW'(block_address_i[BL-1:0]);
  assign in_d   = PoW'(signed'(soff_q[cs_q]));
  assign so1    = in_off - in_d;
  assign so2    = in_off - (in_d <<< 1);
  assign so3    = so2 - in_d;
  assign po0    = in_off + in_d;
  assign e_d    = PoW'(signed'(soff_q[esel_q]));

  assign inc = sb_stat.hit[sop_pkg::TgtDemand] ?
               (3'd1 + {2'b00, sb_stat.hit[1] & tv_q[1]} + {2'b00, sb_stat.hit[2] & tv_q[2]}
                     + {2'b00, sb_stat.hit[3] & tv_q[3]}) : 3'd0;
  assign sc_sum = {1'b0, sc_q[cs_q]} + (SB + 1)'(inc);

  assign sb_ctrl.start  = accept;
  assign sb_ctrl.insert = (state_q == sop_pkg::StUpdate) && tv_q[sop_pkg::TgtInsert];
  assign sb_ctrl.clear  = (state_q == sop_pkg::StUpdate) && phase_end;

  sop_sandbox #(
    .AddrW (AB),
    .Depth (SANDBOX_DEPTH)
  ) u_sandbox (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sb_ctrl),
    .tgt_i  (tgt_q),
    .stat_o (sb_stat)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      sop_pkg::StIdle: begin
        if (start) state_d = sop_pkg::StScan;
      end
      sop_pkg::StScan: begin
        if (sb_stat.done) state_d = sop_pkg::StUpdate;
      end
      sop_pkg::StUpdate: begin
        state_d = (phase_end && (cs_q == 4'(NS - 1))) ? sop_pkg::StSort : sop_pkg::StEmM;
      end
      sop_pkg::StSort: begin
        if (k_q == 5'(NS - 1)) state_d = sop_pkg::StPush;
      end
      sop_pkg::StPush: begin
        if (k_q >= ncyc) state_d = sop_pkg::StPop;
      end
      sop_pkg::StPop: begin
        if (k_q >= ncyc) state_d = sop_pkg::StEmM;
      end
      sop_pkg::StEmM: begin
        state_d = sop_pkg::StEmS;
      end
      sop_pkg::StEmS: begin
        if (sel_found) begin
          state_d = sop_pkg::StEmLa;
        end else if (m_q == 6'd32) begin
          state_d = sg_q ? sop_pkg::StFlush : sop_pkg::StEmM;
        end else begin
          state_d = sop_pkg::StEmM;
        end
      end
      sop_pkg::StEmLa: begin
        if (!la_ok) begin
          if (sign_stop) state_d = sg_q ? sop_pkg::StFlush : sop_pkg::StEmM;
          else state_d = sop_pkg::StEmS;
        end
      end
      sop_pkg::StFlush: begin
        state_d = sop_pkg::StIdle;
      end
      default: state_d = sop_pkg::StIdle;
    endcase
  end

  always_comb begin
    deg_d = deg_q; oc_d = oc_q; sde_d = sde_q; sdl_d = sdl_q; pl_d = pl_q;
    pd_d = pd_q; soff_d = soff_q; sc_d = sc_q; wq_d = wq_q;
    whead_d = whead_q; wcnt_d = wcnt_q; cs_d = cs_q;
    addr_d = addr_q; tgt_d = tgt_q; tv_d = tv_q; k_d = k_q;
    sg_d = sg_q; m_d = m_q; pend_d = pend_q; esel_d = esel_q; la_d = la_q;
    thr_d = thr_q; po_d = po_q; cnt_d = cnt_q; n_d = n_q;
    hbv_d = hbv_q; hba_d = hba_q; hbp_d = hbp_q;
    ov_d = 1'b0; ol_d = 1'b0; oa_d = oa_q; op_d = op_q;
    tgt_m = '0; soff_ext = '0;

    if (cfg_we_i) begin
      case (cfg_addr_i)
        sop_pkg::CfgDegree:    deg_d = cfg_wdata_i[4:0];
        sop_pkg::CfgStreamEn:  sde_d = cfg_wdata_i[0];
        sop_pkg::CfgStreamLen: sdl_d = cfg_wdata_i[1:0];
        sop_pkg::CfgPhaseLen:  pl_d  = cfg_wdata_i;
        sop_pkg::CfgOffCycled: oc_d  = cfg_wdata_i[4:0];
        default: ;
      endcase
    end

    case (state_q)
      sop_pkg::StIdle: begin
        if (start) begin
          addr_d = block_address_i;
          if (pd_q != 9'd511) pd_d = pd_q + 9'd1;
          tgt_d[0] = block_address_i;
          tgt_d[1] = {block_address_i[AB-1:BL], so1[BL-1:0]};
          tgt_d[2] = {block_address_i[AB-1:BL], so2[BL-1:0]};
          tgt_d[3] = {block_address_i[AB-1:BL], so3[BL-1:0]};
          tgt_d[4] = {block_address_i[AB-1:BL], po0[BL-1:0]};
          tv_d[0]  = 1'b1;
          tv_d[1]  = sde_q && (sdl_q >= 2'd1) && in_page(so1);
          tv_d[2]  = sde_q && (sdl_q >= 2'd2) && in_page(so2);
          tv_d[3]  = sde_q && (sdl_q == 2'd3) && in_page(so3);
          tv_d[4]  = in_page(po0);
          sg_d = 1'b0; m_d = 6'd1; cnt_d = '0; n_d = '0; hbv_d = 1'b0; k_d = '0;
        end
      end
      sop_pkg::StUpdate: begin
        sc_d[cs_q] = sc_sum[SB] ? {SB{1'b1}} : sc_sum[SB-1:0];
        if (phase_end) begin
          pd_d = '0;
          cs_d = (cs_q == 4'(NS - 1)) ? 4'd0 : cs_q + 4'd1;
        end
      end
      sop_pkg::StSort: begin
        for (int i = 0; i < NS - 1; i++) begin
          if ((i % 2) == int'(k_q[0]) && (sc_q[i] < sc_q[i+1])) begin
            sc_d[i]     = sc_q[i+1];
            sc_d[i+1]   = sc_q[i];
            soff_d[i]   = soff_q[i+1];
            soff_d[i+1] = soff_q[i];
          end
        end
        k_d = (k_q == 5'(NS - 1)) ? 5'd0 : k_q + 5'd1;
      end
      sop_pkg::StPush: begin
        if (k_q < ncyc) begin
          if (wcnt_q < 6'(sop_pkg::WaitDepth)) begin
            wq_d[whead_q + wcnt_q[4:0]] = soff_q[4'(NS - 1) - k_q[3:0]];
            wcnt_d = wcnt_q + 6'd1;
          end
          k_d = k_q + 5'd1;
        end else begin
          k_d = '0;
        end
      end
      sop_pkg::StPop: begin
        if (k_q < ncyc) begin
          if (wcnt_q != 6'd0) begin
            soff_d[k_q[3:0] - ncyc[3:0]] = wq_q[whead_q];
            whead_d = whead_q + 5'd1;
            wcnt_d  = wcnt_q - 6'd1;
          end
          sc_d[k_q[3:0] - ncyc[3:0]] = '0;
          k_d = k_q + 5'd1;
        end
      end
      sop_pkg::StEmM: begin
        tgt_m = sg_q ? (7'd0 - {1'b0, m_q}) : {1'b0, m_q};
        for (int s = 0; s < NS; s++) begin
          soff_ext  = {soff_q[s][sop_pkg::OffW-1], soff_q[s]};
          pend_d[s] = (soff_ext == tgt_m);
        end
      end
      sop_pkg::StEmS: begin
        if (sel_found) begin
          pend_d[sel] = 1'b0;
          esel_d = sel;
          la_d   = 3'd1;
          thr_d  = sop_pkg::ThrW'(pl_q);
          po_d   = PoW'(addr_q[BL-1:0]) + PoW'(signed'(soff_q[sel]));
        end else if (m_q == 6'd32) begin
          sg_d = 1'b1; m_d = 6'd1; cnt_d = '0;
        end else begin
          m_d = m_q + 6'd1;
        end
      end
      sop_pkg::StEmLa: begin
        if (la_ok) begin
          if ((sc_q[esel_q] >= SB'(thr_q)) && in_page(po_q) && (n_q < 7'(sop_pkg::MaxOut))) begin
            if (hbv_q) begin
              ov_d = 1'b1; oa_d = hba_q; op_d = hbp_q; ol_d = 1'b0;
            end
            hbv_d = 1'b1;
            hba_d = {addr_q[AB-1:BL], po_q[BL-1:0]};
            hbp_d = n_q[5:0];
            n_d   = n_q + 7'd1;
            cnt_d = cnt_q + 7'd1;
          end
          la_d  = la_q + 3'd1;
          thr_d = thr_q + sop_pkg::ThrW'(pl_q);
          po_d  = po_q + e_d;
        end else if (sign_stop && !sg_q) begin
          sg_d = 1'b1; m_d = 6'd1; cnt_d = '0;
        end
      end
      sop_pkg::StFlush: begin
        if (hbv_q) begin
          ov_d = 1'b1; oa_d = hba_q; op_d = hbp_q; ol_d = 1'b1;
        end
        hbv_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sop_pkg::StIdle;
      deg_q   <= 5'd4;
      sde_q   <= 1'b1;
      sdl_q   <= 2'd3;
      pl_q    <= 9'd256;
      oc_q    <= 5'd4;
      pd_q    <= '0;
      for (int i = 0; i < NS; i++) begin
        soff_q[i] <= (i < 8) ? sop_pkg::OffW'(i + 1) : sop_pkg::OffW'(i - 16);
        sc_q[i]   <= '0;
      end
      for (int i = 0; i < sop_pkg::WaitDepth; i++) begin
        if (i < 8) wq_q[i] <= sop_pkg::OffW'(i + 9);
        else if (i < 16) wq_q[i] <= sop_pkg::OffW'(i - 24);
        else wq_q[i] <= '0;
      end
      whead_q <= '0;
      wcnt_q  <= 6'd16;
      cs_q    <= '0;
      tv_q    <= '0;
      k_q     <= '0;
      sg_q    <= 1'b0;
      m_q     <= 6'd1;
      pend_q  <= '0;
      la_q    <= 3'd1;
      cnt_q   <= '0;
      n_q     <= '0;
      hbv_q   <= 1'b0;
      ov_q    <= 1'b0;
      ol_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      deg_q   <= deg_d;
      sde_q   <= sde_d;
      sdl_q   <= sdl_d;
      pl_q    <= pl_d;
      oc_q    <= oc_d;
      pd_q    <= pd_d;
      soff_q  <= soff_d;
      sc_q    <= sc_d;
      wq_q    <= wq_d;
      whead_q <= whead_d;
      wcnt_q  <= wcnt_d;
      cs_q    <= cs_d;
      tv_q    <= tv_d;
      k_q     <= k_d;
      sg_q    <= sg_d;
      m_q     <= m_d;
      pend_q  <= pend_d;
      la_q    <= la_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      hbv_q   <= hbv_d;
      ov_q    <= ov_d;
      ol_q    <= ol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    tgt_q  <= tgt_d;
    esel_q <= esel_d;
    thr_q  <= thr_d;
    po_q   <= po_d;
    hba_q  <= hba_d;
    hbp_q  <= hbp_d;
    oa_q   <= oa_d;
    op_q   <= op_d;
  end

  assign out_valid_o        = ov_q;
  assign prefetch_address_o = oa_q;
  assign priority_index_o   = op_q;
  assign last_of_run_o      = ol_q;

endmodule

// ----- hw/rtl/sop_checker.sv -----
// Port-level checks for the sandbox offset prefetcher and their binding.
module sop_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic out_valid_o,
  input logic last_of_run_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("Accepted item did not raise busy.");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_of_run_o |-> out_valid_o) else $error("Last marker without a result.");

  a_last_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_run_o |=> !out_valid_o)
    else $error("Result followed the last of a run.");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> busy)
    else $error("Non-final result while idle.");

endmodule

bind sandbox_offset_prefetcher_top sop_checker u_sop_checker (.*);
